[rtl/obrb_pkg.sv]
`timescale 1ns / 1ps

package obrb_pkg;

   // field widths of one transaction
   localparam int DATA_W    = 8;
   localparam int OP_W      = 2;
   localparam int CAP_REG_W = 9;

   // capacity after reset, before clamping to the store depth
   localparam int CAP_RESET = 256;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic exec;    // transaction accepted: apply operation, launch store read
      logic finish;  // load the result register
   } obrb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free; // result register empty or being emptied this cycle
   } obrb_status_type;

endpackage

[rtl/obrb_if.sv]
`timescale 1ns / 1ps

// request channel
interface obrb_req_if import obrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output op, output write_data, input ready);
   modport sink (input valid, input op, input write_data, output ready);
endinterface

// response channel
interface obrb_rsp_if import obrb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DATA_W-1:0]    read_data;
   logic                 read_ok;
   logic [CAP_REG_W-1:0] fill_count;
   logic                 full_flag;
   logic                 empty_flag;
   logic [DATA_W-1:0]    newest_value;
   logic                 newest_ok;
   logic [DATA_W-1:0]    second_newest_value;
   logic                 second_newest_ok;

   modport source (output valid, output read_data, output read_ok, output fill_count,
                   output full_flag, output empty_flag, output newest_value,
                   output newest_ok, output second_newest_value,
                   output second_newest_ok, input ready);
   modport sink (input valid, input read_data, input read_ok, input fill_count,
                 input full_flag, input empty_flag, input newest_value,
                 input newest_ok, input second_newest_value,
                 input second_newest_ok, output ready);
endinterface

[rtl/obrb_datapath.sv]
`timescale 1ns / 1ps

module obrb_datapath import obrb_pkg::*; #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [OP_W-1:0]      req_op,
   input  logic [DATA_W-1:0]    req_write_data,
   input  logic                 csr_we,
   input  logic [CAP_REG_W-1:0] csr_wdata,
   input  obrb_cmd_type         cmd,
   output obrb_status_type      status,
   obrb_rsp_if.source           rsp
);

   localparam int PtrW = $clog2(STORE_DEPTH);
   localparam int CapW = $clog2(STORE_DEPTH + 1);
   localparam int ResetCapInt = (STORE_DEPTH < CAP_RESET) ? STORE_DEPTH : CAP_RESET;
   localparam logic [CapW-1:0] ResetCap = CapW'(ResetCapInt);

   // advance a pointer, wrapping at the active capacity
   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p,
                                            input logic [CapW-1:0] cap);
      logic [CapW-1:0] p_inc;
      p_inc = CapW'(p) + CapW'(1);
      return (p_inc == cap) ? '0 : p_inc[PtrW-1:0];
   endfunction

   logic [DATA_W-1:0]    store_ff [STORE_DEPTH];
   logic [DATA_W-1:0]    mem_q_ff;
   logic [CapW-1:0]      cap_ff, cap_in, cap_wr;
   logic [PtrW-1:0]      wp_ff, wp_in;
   logic [PtrW-1:0]      rp_ff, rp_in;
   logic [CapW-1:0]      count_ff, count_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [DATA_W-1:0]    newest_ff, newest_in;
   logic [DATA_W-1:0]    second_ff, second_in;
   logic                 out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]    o_read_data_ff;
   logic                 o_read_ok_ff;
   logic [CAP_REG_W-1:0] o_fill_ff;
   logic                 o_full_ff;
   logic                 o_empty_ff;
   logic [DATA_W-1:0]    o_newest_ff;
   logic                 o_newest_ok_ff;
   logic [DATA_W-1:0]    o_second_ff;
   logic                 o_second_ok_ff;
   logic                 is_full;
   logic                 has_one;
   logic                 has_two;
   logic                 do_write;

   // clamp a written capacity into 1 .. STORE_DEPTH
   always_comb begin
      priority if (csr_wdata == '0) begin
         cap_wr = CapW'(1);
      end else if ({{(32-CAP_REG_W){1'b0}}, csr_wdata} > 32'(STORE_DEPTH)) begin
         cap_wr = CapW'(STORE_DEPTH);
      end else begin
         cap_wr = CapW'(csr_wdata);
      end
   end

   assign is_full  = (count_ff == cap_ff);
   assign has_one  = (count_ff != '0);
   assign has_two  = (count_ff > CapW'(1));
   assign do_write = cmd.exec && (req_op == OP_WRITE);

   // pointer, count and peek update
   always_comb begin
      cap_in    = cap_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      count_in  = count_ff;
      rd_ok_in  = rd_ok_ff;
      newest_in = newest_ff;
      second_in = second_ff;
      if (csr_we) begin
         cap_in   = cap_wr;
         wp_in    = '0;
         rp_in    = '0;
         count_in = '0;
      end else if (cmd.exec) begin
         rd_ok_in = 1'b0;
         unique case (req_op)
            OP_WRITE: begin
               wp_in     = bump(wp_ff, cap_ff);
               newest_in = req_write_data;
               second_in = newest_ff;
               if (is_full) begin
                  rp_in = bump(rp_ff, cap_ff);
               end else begin
                  count_in = count_ff + CapW'(1);
               end
            end
            OP_READ: begin
               if (has_one) begin
                  rd_ok_in = 1'b1;
                  rp_in    = bump(rp_ff, cap_ff);
                  count_in = count_ff - CapW'(1);
               end
            end
            OP_CLEAR: begin
               wp_in    = '0;
               rp_in    = '0;
               count_in = '0;
            end
            default: begin
               // unused code: state untouched, status still reported
            end
         endcase
      end
   end

   // result register handshake
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign status.out_free = !out_valid_ff || rsp.ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= ResetCap;
         wp_ff        <= '0;
         rp_ff        <= '0;
         count_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         count_ff     <= count_in;
         rd_ok_ff     <= rd_ok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // peek registers
   always_ff @(posedge clock) begin
      newest_ff <= newest_in;
      second_ff <= second_in;
   end

   // byte store: one write port at the head, registered read at the tail
   always_ff @(posedge clock) begin
      if (do_write) begin
         store_ff[wp_ff] <= req_write_data;
      end
      if (cmd.exec) begin
         mem_q_ff <= store_ff[rp_ff];
      end
   end

   // result register, loaded from the post-operation state
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         o_read_data_ff <= rd_ok_ff ? mem_q_ff : '0;
         o_read_ok_ff   <= rd_ok_ff;
         o_fill_ff      <= CAP_REG_W'(count_ff);
         o_full_ff      <= is_full;
         o_empty_ff     <= !has_one;
         o_newest_ff    <= has_one ? newest_ff : '0;
         o_newest_ok_ff <= has_one;
         o_second_ff    <= has_two ? second_ff : '0;
         o_second_ok_ff <= has_two;
      end
   end

   assign rsp.valid               = out_valid_ff;
   assign rsp.read_data           = o_read_data_ff;
   assign rsp.read_ok             = o_read_ok_ff;
   assign rsp.fill_count          = o_fill_ff;
   assign rsp.full_flag           = o_full_ff;
   assign rsp.empty_flag          = o_empty_ff;
   assign rsp.newest_value        = o_newest_ff;
   assign rsp.newest_ok           = o_newest_ok_ff;
   assign rsp.second_newest_value = o_second_ff;
   assign rsp.second_newest_ok    = o_second_ok_ff;

   // fill never exceeds the active capacity
   assert property (@(posedge clock) disable iff (reset) count_ff <= cap_ff)
      else $error("fill count above capacity");

   // pointers stay inside the active window
   assert property (@(posedge clock) disable iff (reset)
      (CapW'(wp_ff) < cap_ff) && (CapW'(rp_ff) < cap_ff))
      else $error("pointer outside active window");

   // equal pointers mean empty or full
   assert property (@(posedge clock) disable iff (reset)
      (wp_ff == rp_ff) |-> ((count_ff == '0) || (count_ff == cap_ff)))
      else $error("pointers and fill count disagree");

   // the result register is never overwritten while still held
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !out_valid_ff)
      else $error("result loaded over pending result");

endmodule

[rtl/obrb_ctrl.sv]
`timescale 1ns / 1ps

module obrb_ctrl import obrb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  obrb_status_type status,
   output logic            req_ready,
   output obrb_cmd_type    cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs; nothing is taken in while reset is high
   always_comb begin
      req_ready  = 1'b0;
      cmd.exec   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free && !reset;
            cmd.exec  = req_valid && status.out_free && !reset;
         end
         ST_FETCH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/overwriting_byte_ring_buffer.sv]
`timescale 1ns / 1ps
// result: a request accepted in ST_IDLE moves the controller to ST_FETCH, which loads the result register
// pacing: the next request waits until ST_FETCH has passed, as the registered read port of
//   the byte store needs (data appears the cycle after the tail pointer is applied);
//   a result not yet taken holds off the next request
// reset: pointers and fill count cleared, capacity = min(256, STORE_DEPTH), request
//   side not ready while reset is high; store contents are not cleared

module overwriting_byte_ring_buffer import obrb_pkg::*; #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   obrb_req_if.sink             req,
   obrb_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [CAP_REG_W-1:0] csr_wdata
);

   obrb_cmd_type    cmd;
   obrb_status_type status;
   logic            ready;

   // sequencing
   obrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .status    (status),
      .req_ready (ready),
      .cmd       (cmd)
   );

   assign req.ready = ready;

   // store, pointers and result register
   obrb_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req.op),
      .req_write_data (req.write_data),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp            (rsp)
   );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import obrb_pkg::*;

   localparam int STORE_DEPTH   = 256;
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS   = 40;
   localparam int HOLD_CYCLES   = 80;

   // op code with no defined operation
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // status reported for every transaction
   typedef struct packed {
      logic [DATA_W-1:0]    read_data;
      logic                 read_ok;
      logic [CAP_REG_W-1:0] fill_count;
      logic                 full_flag;
      logic                 empty_flag;
      logic [DATA_W-1:0]    newest_value;
      logic                 newest_ok;
      logic [DATA_W-1:0]    second_newest_value;
      logic                 second_newest_ok;
   } ring_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CAP_REG_W-1:0] csr_wdata;

   obrb_req_if req_bus ();
   obrb_rsp_if rsp_bus ();

   overwriting_byte_ring_buffer #(.STORE_DEPTH(STORE_DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the ring
   logic [DATA_W-1:0]    ring_mem [STORE_DEPTH];
   int unsigned          head_ptr = 0;
   int unsigned          tail_ptr = 0;
   bit                   ring_full = 1'b0;
   logic [CAP_REG_W-1:0] capacity_reg = CAP_REG_W'(CAP_RESET);

   ring_result_type pending_results [$];
   int              mismatch_count = 0;
   bit              pacing_on = 1'b1;
   int unsigned     rsp_hold_cycles = 0;

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void empty_ring();
      head_ptr  = 0;
      tail_ptr  = 0;
      ring_full = 1'b0;
   endfunction

   function automatic int unsigned next_slot(int unsigned slot, int unsigned span);
      return (slot + 1 >= span) ? 0 : slot + 1;
   endfunction

   // apply one operation to the shadow ring and work out the status it reports
   function automatic ring_result_type advance_ring(logic [OP_W-1:0] op,
                                                    logic [DATA_W-1:0] data);
      ring_result_type r;
      int unsigned     span;
      int unsigned     held;
      r    = '0;
      span = capacity_reg;
      if (span == 0) span = 1;
      if (span > STORE_DEPTH) span = STORE_DEPTH;
      // pointers outside the active window count as an empty ring
      if (head_ptr >= span || tail_ptr >= span) empty_ring();
      case (op)
         OP_WRITE: begin
            ring_mem[head_ptr] = data;
            head_ptr = next_slot(head_ptr, span);
            // full ring: the oldest byte is dropped
            if (ring_full) tail_ptr = next_slot(tail_ptr, span);
            if (head_ptr == tail_ptr) ring_full = 1'b1;
         end
         OP_READ: begin
            if (ring_full || head_ptr != tail_ptr) begin
               r.read_data = ring_mem[tail_ptr];
               r.read_ok   = 1'b1;
               tail_ptr    = next_slot(tail_ptr, span);
               ring_full   = 1'b0;
            end
         end
         OP_CLEAR: begin
            empty_ring();
         end
         default: begin
         end
      endcase
      if (ring_full) held = span;
      else if (head_ptr >= tail_ptr) held = head_ptr - tail_ptr;
      else held = span - tail_ptr + head_ptr;
      r.fill_count = held[CAP_REG_W-1:0];
      r.full_flag  = ring_full;
      r.empty_flag = (held == 0);
      // peeks behind the head, wrapping at the active capacity
      if (held >= 1) begin
         r.newest_value = ring_mem[(head_ptr + span - 1) % span];
         r.newest_ok    = 1'b1;
      end
      if (held >= 2) begin
         r.second_newest_value = ring_mem[(head_ptr + 2 * span - 2) % span];
         r.second_newest_ok    = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [CAP_REG_W-1:0] got,
                                  logic [CAP_REG_W-1:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(string what, logic [CAP_REG_W-1:0] got,
                              logic [CAP_REG_W-1:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic compare_result(ring_result_type want);
      check_field("read_data", CAP_REG_W'(rsp_bus.read_data),
                  CAP_REG_W'(want.read_data));
      check_field("read_ok", CAP_REG_W'(rsp_bus.read_ok), CAP_REG_W'(want.read_ok));
      check_field("fill_count", rsp_bus.fill_count, want.fill_count);
      check_field("full_flag", CAP_REG_W'(rsp_bus.full_flag), CAP_REG_W'(want.full_flag));
      check_field("empty_flag", CAP_REG_W'(rsp_bus.empty_flag),
                  CAP_REG_W'(want.empty_flag));
      check_field("newest_value", CAP_REG_W'(rsp_bus.newest_value),
                  CAP_REG_W'(want.newest_value));
      check_field("newest_ok", CAP_REG_W'(rsp_bus.newest_ok), CAP_REG_W'(want.newest_ok));
      check_field("second_newest_value", CAP_REG_W'(rsp_bus.second_newest_value),
                  CAP_REG_W'(want.second_newest_value));
      check_field("second_newest_ok", CAP_REG_W'(rsp_bus.second_newest_ok),
                  CAP_REG_W'(want.second_newest_ok));
   endtask

   // predict on each accepted request, check each accepted response
   always @(posedge clock) begin : scoreboard
      if (!reset && req_bus.valid && req_bus.ready)
         pending_results.push_back(advance_ring(req_bus.op, req_bus.write_data));
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0)
            report_mismatch("response with nothing pending", '0, '0);
         else
            compare_result(pending_results.pop_front());
      end
   end

   // response side pacing, with an occasional long hold-off
   initial begin : rsp_pacing
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = pacing_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1 && rsp_hold_cycles == 0);
      end
   end

   // stop the run when no transaction moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("overwriting_byte_ring_buffer verification failed");
      $finish;
   end

   // one request transaction; valid stays high when the next follows at once
   task automatic send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] data);
      int gap;
      gap = pacing_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.write_data <= data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic send_random(int write_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) send_item(OP_CLEAR, DATA_W'($urandom_range(0, 255)));
      else if (roll < 6) send_item(OP_UNUSED, DATA_W'($urandom_range(0, 255)));
      else if (roll < 6 + write_pct * 94 / 100)
         send_item(OP_WRITE, DATA_W'($urandom_range(0, 255)));
      else send_item(OP_READ, DATA_W'($urandom_range(0, 255)));
   endtask

   function automatic int pick_write_pct();
      case ($urandom_range(0, 3))
         0: return 20;
         1: return 50;
         2: return 70;
         default: return 95;
      endcase
   endfunction

   // stop offering, then wait for every pending response and the pipeline to empty
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, which also empties the ring
   task automatic set_capacity(logic [CAP_REG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      capacity_reg = value;
      empty_ring();
   endtask

   // optional run of pure writes to fill and wrap, then mixed traffic
   task automatic run_capacity_phase(logic [CAP_REG_W-1:0] cap, int count, int fill_writes);
      int write_pct;
      settle_idle();
      set_capacity(cap);
      write_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i < fill_writes) begin
            send_item(OP_WRITE, DATA_W'($urandom_range(0, 255)));
         end else begin
            if ((i - fill_writes) % 20 == 0) write_pct = pick_write_pct();
            send_random(write_pct);
         end
      end
   endtask

   // reset capacity: empty reads, clear, unused op, byte extremes
   task automatic test_reset_capacity_ops();
      send_item(OP_READ, 8'h00);
      send_item(OP_UNUSED, 8'hFF);
      send_item(OP_CLEAR, 8'h00);
      send_item(OP_WRITE, 8'h00);
      send_item(OP_WRITE, 8'hFF);
      send_item(OP_UNUSED, 8'h00);
      send_item(OP_WRITE, 8'h5A);
      send_item(OP_READ, 8'hFF);
      send_item(OP_CLEAR, 8'hFF);
      send_item(OP_READ, 8'h00);
      send_item(OP_WRITE, 8'hA5);
   endtask

   // zero acts as one, two wraps and overwrites, oversize clamps to the store
   task automatic test_capacity_extremes();
      settle_idle();
      set_capacity(9'd0);
      send_item(OP_WRITE, 8'h11);
      send_item(OP_WRITE, 8'h22);
      send_item(OP_READ, 8'h00);
      send_item(OP_READ, 8'h00);
      settle_idle();
      set_capacity(9'd2);
      send_item(OP_WRITE, 8'h01);
      send_item(OP_WRITE, 8'h02);
      send_item(OP_WRITE, 8'h03);
      send_item(OP_READ, 8'h00);
      send_item(OP_READ, 8'h00);
      send_item(OP_READ, 8'h00);
      settle_idle();
      set_capacity(9'd511);
      send_item(OP_WRITE, 8'hFF);
      send_item(OP_READ, 8'h00);
   endtask

   task automatic test_random_capacities();
      run_capacity_phase(9'd1, 80, 0);
      run_capacity_phase(9'd2, 80, 0);
      run_capacity_phase(9'd3, 80, 0);
      run_capacity_phase(9'd4, 80, 0);
      run_capacity_phase(9'd5, 80, 0);
      run_capacity_phase(9'd8, 80, 0);
      run_capacity_phase(9'd0, 80, 0);
      run_capacity_phase(9'd16, 80, 0);
      run_capacity_phase(CAP_REG_W'($urandom_range(6, 40)), 80, 0);
      run_capacity_phase(9'd255, 300, 270);
      run_capacity_phase(9'd256, 300, 270);
      run_capacity_phase(9'd511, 100, 0);
   endtask

   // back-to-back traffic on both sides
   task automatic test_full_throughput();
      pacing_on = 1'b0;
      run_capacity_phase(9'd6, 120, 0);
      pacing_on = 1'b1;
   endtask

   // response side holds off while requests keep coming, so the input stalls
   task automatic test_receiver_hold();
      settle_idle();
      set_capacity(9'd3);
      pacing_on       = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 40; i++) send_random(70);
      pacing_on = 1'b1;
   endtask

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.op         <= OP_WRITE;
      req_bus.write_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_capacity_ops();
      test_capacity_extremes();
      test_random_capacities();
      test_full_throughput();
      test_receiver_hold();

      settle_idle();
      if (pending_results.size() != 0)
         report_mismatch("responses never delivered",
                         CAP_REG_W'(pending_results.size()), '0);
      if (mismatch_count == 0)
         $display("overwriting_byte_ring_buffer verification clean");
      else
         $display("overwriting_byte_ring_buffer verification failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/obrb_pkg.sv
rtl/obrb_if.sv
rtl/obrb_datapath.sv
rtl/obrb_ctrl.sv
rtl/overwriting_byte_ring_buffer.sv
verif/testbench.sv
